FILE: rtl/core/ldfr_pkg.sv
// package for the distance frame receiver: codes, constants and types
`default_nettype none

package ldfr_pkg;

   localparam int POINTS_DEFAULT = 160;

   localparam logic [7:0] HDR_BYTE  = 8'hAA;
   localparam logic [7:0] CMD_DIST  = 8'h02;
   localparam int         HDR_RUN   = 4;
   localparam int         META_LAST = 5;
   localparam int         TS_LAST   = 3;
   localparam int         PT_LOW    = 4;
   localparam int         PT_HIGH   = 5;

   localparam int KIND_W   = 2;
   localparam int INDEX_W  = 8;
   localparam int DIST_W   = 9;
   localparam int CONF_W   = 8;
   localparam int TS_W     = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_POINT     = 2'd0,
      KIND_TIMESTAMP = 2'd1,
      KIND_DONE      = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_CSUM_BAD = 2'd1,
      STATUS_HDR_BAD  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'b0001,
      PH_META    = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_CSUM    = 4'b1000
   } phase_type;

endpackage

`default_nettype wire

FILE: rtl/core/lidar_distance_frame_receiver.sv
// top level of the distance frame receiver: header hunt, meta check, payload stream, checksum
//
// Takes one received byte per word on the req_ channel and returns frame results on the rsp_
// channel: a timestamp word, then one word per point (distance and confidence), then a final
// word with the frame status (good, checksum mismatch, or wrong command/length, the last
// ending the frame right after the six meta bytes). Each byte is decoded in the cycle it is
// accepted and its result, if any, appears in the result register on the next cycle, and
// a byte can be taken every cycle. The only thing that stops input is a result still held
// in the result register while rsp_ready is low. Points stream out before the checksum
// byte arrives, so a bad frame still delivers its points.
`default_nettype none

module lidar_distance_frame_receiver #(
   parameter int POINTS = ldfr_pkg::POINTS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [7:0]                      req_rx_byte,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [ldfr_pkg::KIND_W-1:0]     rsp_kind,
   output      logic [ldfr_pkg::INDEX_W-1:0]    rsp_point_index,
   output      logic [ldfr_pkg::DIST_W-1:0]     rsp_distance,
   output      logic [ldfr_pkg::CONF_W-1:0]     rsp_confidence,
   output      logic [ldfr_pkg::TS_W-1:0]       rsp_timestamp,
   output      logic [ldfr_pkg::STATUS_W-1:0]   rsp_status
);
   import ldfr_pkg::*;

   localparam logic [15:0]        PAYLOAD_LEN = 16'(4 + 2 * POINTS);
   localparam logic [INDEX_W-1:0] POINTS_LAST = INDEX_W'(POINTS - 1);

   phase_type             phase_ff, phase_in;
   logic [1:0]            header_run_ff, header_run_in;
   logic [2:0]            byte_position_ff, byte_position_in;
   logic [7:0]            command_seen_ff, command_seen_in;
   logic [7:0]            length_low_ff, length_low_in;
   logic [7:0]            running_sum_ff, running_sum_in;
   logic [23:0]           held_bytes_ff, held_bytes_in;
   logic [INDEX_W-1:0]    point_count_ff, point_count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              kind_ff, kind_in;
   logic [INDEX_W-1:0]    index_ff, index_in;
   logic [DIST_W-1:0]     distance_ff, distance_in;
   logic [CONF_W-1:0]     confidence_ff, confidence_in;
   logic [TS_W-1:0]       timestamp_ff, timestamp_in;
   status_type            status_ff, status_in;

   logic                  accept;
   logic [7:0]            sum_next;
   logic [15:0]           length_full;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign sum_next    = running_sum_ff + req_rx_byte;
   assign length_full = {req_rx_byte, length_low_ff};

   always_comb begin
      phase_in         = phase_ff;
      header_run_in    = header_run_ff;
      byte_position_in = byte_position_ff;
      command_seen_in  = command_seen_ff;
      length_low_in    = length_low_ff;
      running_sum_in   = running_sum_ff;
      held_bytes_in    = held_bytes_ff;
      point_count_in   = point_count_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      kind_in       = kind_ff;
      index_in      = index_ff;
      distance_in   = distance_ff;
      confidence_in = confidence_ff;
      timestamp_in  = timestamp_ff;
      status_in     = status_ff;

      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == HDR_BYTE) begin
                  if (header_run_ff == 2'(HDR_RUN - 1)) begin
                     phase_in         = PH_META;
                     header_run_in    = '0;
                     byte_position_in = '0;
                     running_sum_in   = '0;
                     command_seen_in  = '0;
                     length_low_in    = '0;
                  end else begin
                     header_run_in = header_run_ff + 2'd1;
                  end
               end else begin
                  header_run_in = '0;
               end
            end

            PH_META: begin
               running_sum_in = sum_next;
               if (byte_position_ff == 3'd1) begin
                  command_seen_in = req_rx_byte;
               end
               if (byte_position_ff == 3'd4) begin
                  length_low_in = req_rx_byte;
               end
               if (byte_position_ff != 3'(META_LAST)) begin
                  byte_position_in = byte_position_ff + 3'd1;
               end else if (command_seen_ff != CMD_DIST || length_full != PAYLOAD_LEN) begin
                  phase_in      = PH_HUNT;
                  header_run_in = '0;
                  rsp_valid_in  = 1'b1;
                  kind_in       = KIND_DONE;
                  index_in      = '0;
                  distance_in   = '0;
                  confidence_in = '0;
                  timestamp_in  = '0;
                  status_in     = STATUS_HDR_BAD;
               end else begin
                  phase_in         = PH_PAYLOAD;
                  byte_position_in = '0;
                  held_bytes_in    = '0;
                  point_count_in   = '0;
               end
            end

            PH_PAYLOAD: begin
               running_sum_in = sum_next;
               if (byte_position_ff < 3'(TS_LAST)) begin
                  held_bytes_in[{byte_position_ff[1:0], 3'b000} +: 8] = req_rx_byte;
                  byte_position_in = byte_position_ff + 3'd1;
               end else if (byte_position_ff == 3'(TS_LAST)) begin
                  held_bytes_in    = '0;
                  byte_position_in = 3'(PT_LOW);
                  rsp_valid_in     = 1'b1;
                  kind_in          = KIND_TIMESTAMP;
                  index_in         = '0;
                  distance_in      = '0;
                  confidence_in    = '0;
                  timestamp_in     = {req_rx_byte, held_bytes_ff};
                  status_in        = STATUS_GOOD;
               end else if (byte_position_ff == 3'(PT_LOW)) begin
                  held_bytes_in    = {16'd0, req_rx_byte};
                  byte_position_in = 3'(PT_HIGH);
               end else begin
                  // high byte completes the point word
                  held_bytes_in    = '0;
                  byte_position_in = 3'(PT_LOW);
                  point_count_in   = point_count_ff + INDEX_W'(1);
                  if (point_count_ff >= POINTS_LAST) begin
                     phase_in = PH_CSUM;
                  end
                  rsp_valid_in  = 1'b1;
                  kind_in       = KIND_POINT;
                  index_in      = point_count_ff;
                  distance_in   = {req_rx_byte[0], held_bytes_ff[7:0]};
                  confidence_in = {req_rx_byte[7:1], 1'b0};
                  timestamp_in  = '0;
                  status_in     = STATUS_GOOD;
               end
            end

            PH_CSUM: begin
               phase_in      = PH_HUNT;
               header_run_in = '0;
               rsp_valid_in  = 1'b1;
               kind_in       = KIND_DONE;
               index_in      = '0;
               distance_in   = '0;
               confidence_in = '0;
               timestamp_in  = '0;
               status_in     = (running_sum_ff == req_rx_byte) ? STATUS_GOOD : STATUS_CSUM_BAD;
            end

            default: begin
               phase_in      = PH_HUNT;
               header_run_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         header_run_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         header_run_ff <= header_run_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_position_ff <= byte_position_in;
      command_seen_ff  <= command_seen_in;
      length_low_ff    <= length_low_in;
      running_sum_ff   <= running_sum_in;
      held_bytes_ff    <= held_bytes_in;
      point_count_ff   <= point_count_in;
      kind_ff          <= kind_in;
      index_ff         <= index_in;
      distance_ff      <= distance_in;
      confidence_ff    <= confidence_in;
      timestamp_ff     <= timestamp_in;
      status_ff        <= status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_point_index = index_ff;
   assign rsp_distance    = distance_ff;
   assign rsp_confidence  = confidence_ff;
   assign rsp_timestamp   = timestamp_ff;
   assign rsp_status      = status_ff;

endmodule

`default_nettype wire

FILE: sim/lidar_distance_frame_receiver_tb.sv
// testbench for the distance frame receiver: byte stream stimulus checked word by word
`timescale 1ns / 100ps

module testbench;
   import ldfr_pkg::*;

   localparam int PAYLOAD_BYTES = 4 + 2 * POINTS_DEFAULT;
   localparam int FRAME_BYTES   = HDR_RUN + META_LAST + 1 + PAYLOAD_BYTES + 1;
   localparam int FILL_RANDOM   = 0;
   localparam int FILL_EXTREME  = 1;
   localparam int ITEM_TARGET   = 900;
   localparam int QUIET_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      kind_type              kind;
      logic [INDEX_W-1:0]    point_index;
      logic [DIST_W-1:0]     distance;
      logic [CONF_W-1:0]     confidence;
      logic [TS_W-1:0]       timestamp;
      status_type            status;
   } frame_word_type;

   typedef struct packed {
      logic [7:0] rx;
      bit         typed;
      kind_type   want_kind;
      status_type want_status;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_rx_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [KIND_W-1:0]     rsp_kind;
   logic [INDEX_W-1:0]    rsp_point_index;
   logic [DIST_W-1:0]     rsp_distance;
   logic [CONF_W-1:0]     rsp_confidence;
   logic [TS_W-1:0]       rsp_timestamp;
   logic [STATUS_W-1:0]   rsp_status;

   // receiver state as predicted
   phase_type   rx_phase  = PH_HUNT;
   int unsigned hdr_count = 0;
   int unsigned pos       = 0;
   logic [7:0]  cmd_byte  = '0;
   logic [15:0] len_field = '0;
   logic [7:0]  sum_acc   = '0;
   logic [23:0] hold      = '0;
   logic [7:0]  pts_done  = '0;

   frame_word_type expected_words [$];
   int unsigned failures      = 0;
   int unsigned bytes_sent    = 0;
   int unsigned points_seen   = 0;
   int unsigned stamps_seen   = 0;
   int unsigned closed [3]    = '{0, 0, 0};
   int unsigned quiet_cycles  = 0;
   bit          steady        = 1'b0;

   // error rows: a wrong command, then a length one past the expected one
   stim_row_type directed_rows [24] = '{
      '{8'h00, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'hAA, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'hAA, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'hFF, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'hAA, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'hAA, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'hAA, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'hAA, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'hAA, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'h01, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'h00, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'hFF, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'h44, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'h01, 1'b1, KIND_DONE,  STATUS_HDR_BAD},
      '{8'hAA, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'hAA, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'hAA, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'hAA, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'h00, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'h02, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'h00, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'h00, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'h45, 1'b0, KIND_POINT, STATUS_GOOD},
      '{8'h01, 1'b1, KIND_DONE,  STATUS_HDR_BAD}
   };

   lidar_distance_frame_receiver dut (.*);

   always #4 clock = ~clock;

   task automatic decode_byte(input logic [7:0] b, output bit emits, output frame_word_type w);
      logic [15:0] raw;
      emits = 1'b0;
      w = '0;
      case (rx_phase)
         PH_HUNT: begin
            if (b != HDR_BYTE) begin
               hdr_count = 0;
            end else if (hdr_count == HDR_RUN - 1) begin
               rx_phase  = PH_META;
               hdr_count = 0;
               pos       = 0;
               sum_acc   = '0;
               cmd_byte  = '0;
               len_field = '0;
            end else begin
               hdr_count++;
            end
         end
         PH_META: begin
            sum_acc += b;
            if (pos == 1) cmd_byte = b;
            else if (pos == 4) len_field[7:0] = b;
            else if (pos == 5) len_field[15:8] = b;
            if (pos < META_LAST) begin
               pos++;
            end else if (cmd_byte != CMD_DIST || len_field != PAYLOAD_BYTES) begin
               rx_phase  = PH_HUNT;
               hdr_count = 0;
               emits     = 1'b1;
               w.kind    = KIND_DONE;
               w.status  = STATUS_HDR_BAD;
            end else begin
               rx_phase = PH_PAYLOAD;
               pos      = 0;
               hold     = '0;
               pts_done = '0;
            end
         end
         PH_PAYLOAD: begin
            sum_acc += b;
            if (pos < TS_LAST) begin
               hold[8*pos +: 8] = b;
               pos++;
            end else if (pos == TS_LAST) begin
               emits       = 1'b1;
               w.kind      = KIND_TIMESTAMP;
               w.timestamp = {b, hold};
               hold        = '0;
               pos         = PT_LOW;
            end else if (pos == PT_LOW) begin
               hold = {16'h0000, b};
               pos  = PT_HIGH;
            end else begin
               raw           = {b, hold[7:0]};
               emits         = 1'b1;
               w.kind        = KIND_POINT;
               w.point_index = pts_done;
               w.distance    = raw[8:0];
               w.confidence  = {raw[15:9], 1'b0};
               hold          = '0;
               pos           = PT_LOW;
               pts_done++;
               if (pts_done >= POINTS_DEFAULT) rx_phase = PH_CSUM;
            end
         end
         default: begin
            emits     = 1'b1;
            w.kind    = KIND_DONE;
            w.status  = (sum_acc == b) ? STATUS_GOOD : STATUS_CSUM_BAD;
            rx_phase  = PH_HUNT;
            hdr_count = 0;
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input frame_word_type typed_word = '0);
      bit             emits;
      frame_word_type w;
      while (!steady && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      decode_byte(b, emits, w);
      if (typed) expected_words.push_back(typed_word);
      else if (emits) expected_words.push_back(w);
   endtask

   // hold off the sender until every outstanding word has been returned
   task automatic drain_words();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len, input int fill,
                             input bit sum_ok);
      logic [7:0]  meta [6];
      logic [7:0]  sum;
      logic [7:0]  b;
      logic [15:0] pt;
      sum = '0;
      meta[0] = 8'($urandom);
      meta[1] = cmd;
      meta[2] = 8'($urandom);
      meta[3] = 8'($urandom);
      meta[4] = len[7:0];
      meta[5] = len[15:8];
      repeat (HDR_RUN) send_byte(HDR_BYTE);
      foreach (meta[i]) begin
         send_byte(meta[i]);
         sum += meta[i];
      end
      if (cmd == CMD_DIST && len == PAYLOAD_BYTES) begin
         for (int i = 0; i < 4; i++) begin
            b = (fill == FILL_RANDOM) ? 8'($urandom) : 8'hFF;
            send_byte(b);
            sum += b;
         end
         for (int i = 0; i < POINTS_DEFAULT; i++) begin
            if (fill == FILL_EXTREME) begin
               case (i % 4)
                  0:       pt = 16'h0000;
                  1:       pt = 16'hFFFF;
                  2:       pt = 16'h01FF;
                  default: pt = 16'hFE00;
               endcase
            end else begin
               pt = 16'($urandom);
            end
            send_byte(pt[7:0]);
            send_byte(pt[15:8]);
            sum += pt[7:0];
            sum += pt[15:8];
         end
         send_byte(sum_ok ? sum : 8'(sum + 8'($urandom_range(1, 255))));
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   // result side: random back-pressure, each word checked against the oldest expectation
   initial begin
      frame_word_type want;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: kind %0d, status %0d", rsp_kind, rsp_status);
               failures++;
            end else begin
               want = expected_words.pop_front();
               compare_field("kind", want.kind, rsp_kind);
               compare_field("point_index", want.point_index, rsp_point_index);
               compare_field("distance", want.distance, rsp_distance);
               compare_field("confidence", want.confidence, rsp_confidence);
               compare_field("timestamp", want.timestamp, rsp_timestamp);
               compare_field("status", want.status, rsp_status);
               case (want.kind)
                  KIND_POINT:     points_seen++;
                  KIND_TIMESTAMP: stamps_seen++;
                  default:        closed[int'(want.status)]++;
               endcase
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= 33);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("lidar_distance_frame_receiver regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      frame_word_type typed_word;
      logic [7:0]  cmd;
      logic [15:0] len;
      logic [7:0]  b;
      int          pick;
      bit          sum_bad_sent;
      sum_bad_sent = 1'b0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         typed_word        = '0;
         typed_word.kind   = directed_rows[i].want_kind;
         typed_word.status = directed_rows[i].want_status;
         send_byte(directed_rows[i].rx, directed_rows[i].typed, typed_word);
      end

      // field extremes: one clean frame with no idling on either side
      steady <= 1'b1;
      send_frame(CMD_DIST, 16'(PAYLOAD_BYTES), FILL_EXTREME, 1'b1);
      steady <= 1'b0;
      drain_words();

      while (bytes_sent < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 55 && bytes_sent + FRAME_BYTES <= ITEM_TARGET) begin
            // the first random frame always carries a wrong checksum
            send_frame(CMD_DIST, 16'(PAYLOAD_BYTES), FILL_RANDOM,
                       sum_bad_sent && ($urandom_range(3) != 0));
            sum_bad_sent = 1'b1;
         end else if (pick < 75) begin
            cmd = 8'($urandom);
            len = ($urandom_range(3) == 0) ? 16'(PAYLOAD_BYTES) ^ (16'h1 << $urandom_range(15))
                                           : 16'($urandom);
            if ($urandom_range(1)) cmd = CMD_DIST;
            else len = 16'(PAYLOAD_BYTES);
            if (cmd == CMD_DIST && len == PAYLOAD_BYTES) len = len + 16'd1;
            send_frame(cmd, len, FILL_RANDOM, 1'b1);
         end else if (pick < 92) begin
            // line noise and short header runs that never reach four
            repeat ($urandom_range(1, 8)) begin
               b = 8'($urandom);
               send_byte(b == HDR_BYTE ? ~b : b);
            end
            repeat ($urandom_range(0, HDR_RUN - 1)) send_byte(HDR_BYTE);
            send_byte(8'($urandom_range(0, HDR_BYTE - 1)));
         end else begin
            drain_words();
         end
      end

      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d bytes sent; %0d timestamps and %0d points checked", bytes_sent,
               stamps_seen, points_seen);
      $display("frames closed: %0d good, %0d checksum mismatch, %0d header rejected",
               closed[0], closed[1], closed[2]);
      if (failures == 0) begin
         $display("lidar_distance_frame_receiver regression: pass");
      end else begin
         $display("lidar_distance_frame_receiver regression: fail");
      end
      $finish;
   end

endmodule
